/* rtl/core/rme_pkg.sv */
// Shared types and constants for the modular exponentiation block.
// No dependencies.
package rme_pkg;

  localparam int unsigned FieldW  = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgModulus    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPublicExp  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPrivateExp = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StReduce,
    StCheck,
    StMult
  } state_e;

endpackage

/* rtl/core/rsa_modular_exponentiation.sv */
// Right-to-left square-and-multiply modular exponentiation, bit-serial datapath.
// Sequence: base reduction of the message, then one multiply pass per exponent bit up to
//   the highest set bit (none for a zero exponent); the result waits in StCheck for a free output.
// Throughput: one request in flight; the shared shift-and-add multiplier retires one
//   multiplier bit per cycle and computes acc*base and base*base side by side.
// Reset: modulus = 1, both exponents = 0, no request in flight, no result pending.
module rsa_modular_exponentiation #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [rme_pkg::FieldW-1:0]    message_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rme_pkg::FieldW-1:0]    result_o,
  input  logic                          cfg_we_i,
  input  logic [rme_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rme_pkg::FieldW-1:0]    cfg_data_i
);

  localparam int unsigned CntW = $clog2(WIDTH);

  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[WIDTH-1:0];
  endfunction

  rme_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0] mod_q, pub_q, priv_q;
  logic [WIDTH-1:0] msg_q, msg_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] x_q, x_d;     // doubling chain of base
  logic [WIDTH-1:0] ya_q, ya_d;   // multiplier bits for acc*base
  logic [WIDTH-1:0] yb_q, yb_d;   // multiplier bits for base*base
  logic [WIDTH-1:0] p_q, p_d;
  logic [WIDTH-1:0] s_q, s_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [rme_pkg::FieldW-1:0] res_q, res_d;

  logic [63:0]      msg_ext, cfg_ext, acc_ext;
  logic [WIDTH-1:0] msg_w, cfg_w;
  logic [WIDTH:0]   red_t;
  logic [WIDTH-1:0] p_nxt, s_nxt, x_nxt;
  logic             last_bit, out_free, in_acc;

  assign msg_ext = 64'(message_i);
  assign msg_w   = msg_ext[WIDTH-1:0];
  assign cfg_ext = 64'(cfg_data_i);
  assign cfg_w   = cfg_ext[WIDTH-1:0];
  assign acc_ext = 64'(acc_q);

  assign in_stall_o  = (state_q != rme_pkg::StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_bit    = (cnt_q == CntW'(WIDTH - 1));

  always_comb begin
    red_t = {base_q, msg_q[WIDTH-1]};
    if (red_t >= {1'b0, mod_q}) red_t = red_t - {1'b0, mod_q};
    x_nxt = add_mod(x_q, x_q, mod_q);
    p_nxt = ya_q[0] ? add_mod(p_q, x_q, mod_q) : p_q;
    s_nxt = yb_q[0] ? add_mod(s_q, x_q, mod_q) : s_q;
  end

  always_comb begin
    state_d     = state_q;
    msg_d       = msg_q;
    exp_d       = exp_q;
    acc_d       = acc_q;
    base_d      = base_q;
    x_d         = x_q;
    ya_d        = ya_q;
    yb_d        = yb_q;
    p_d         = p_q;
    s_d         = s_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    case (state_q)
      rme_pkg::StIdle: begin
        if (in_acc) begin
          msg_d   = msg_w;
          exp_d   = action_i ? priv_q : pub_q;
          acc_d   = WIDTH'(1);
          base_d  = '0;
          cnt_d   = '0;
          state_d = rme_pkg::StReduce;
        end
      end
      rme_pkg::StReduce: begin
        // restoring remainder, message MSB first
        base_d = red_t[WIDTH-1:0];
        msg_d  = {msg_q[WIDTH-2:0], 1'b0};
        cnt_d  = cnt_q + CntW'(1);
        if (last_bit) state_d = rme_pkg::StCheck;
      end
      rme_pkg::StCheck: begin
        if (exp_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            res_d       = acc_ext[rme_pkg::FieldW-1:0];
            state_d     = rme_pkg::StIdle;
          end
        end else begin
          x_d     = base_q;
          ya_d    = acc_q;
          yb_d    = base_q;
          p_d     = '0;
          s_d     = '0;
          cnt_d   = '0;
          state_d = rme_pkg::StMult;
        end
      end
      rme_pkg::StMult: begin
        x_d   = x_nxt;
        p_d   = p_nxt;
        s_d   = s_nxt;
        ya_d  = ya_q >> 1;
        yb_d  = yb_q >> 1;
        cnt_d = cnt_q + CntW'(1);
        if (last_bit) begin
          if (exp_q[0]) acc_d = p_nxt;
          base_d  = s_nxt;
          exp_d   = exp_q >> 1;
          state_d = rme_pkg::StCheck;
        end
      end
      default: state_d = rme_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rme_pkg::StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      mod_q       <= WIDTH'(1);
      pub_q       <= '0;
      priv_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          rme_pkg::CfgModulus:    mod_q  <= (cfg_w == '0) ? WIDTH'(1) : cfg_w;
          rme_pkg::CfgPublicExp:  pub_q  <= cfg_w;
          rme_pkg::CfgPrivateExp: priv_q <= cfg_w;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q  <= msg_d;
    exp_q  <= exp_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    x_q    <= x_d;
    ya_q   <= ya_d;
    yb_q   <= yb_d;
    p_q    <= p_d;
    s_q    <= s_d;
    res_q  <= res_d;
  end

endmodule

/* dv/rsa_modular_exponentiation_tb.sv */
// Self-checking testbench for rsa_modular_exponentiation: a directed table of requests, then random
// requests over many key settings; typed entries check the table's result, the rest a square-and-multiply model.
// Depends on rme_pkg and the rsa_modular_exponentiation RTL.
module rsa_modular_exponentiation_tb;

  localparam int unsigned Width       = 32;
  localparam int          HalfPeriod  = 6;
  localparam int          ResetCycles = 6;
  localparam int          RandomItems = 520;
  localparam int          HoldCycles  = 3000;
  localparam int          DrainCycles = 1200;
  localparam longint      CycleLimit  = 4_000_000;
  localparam int          NumVectors  = 21;

  localparam logic                        ActEncrypt = 1'b0;
  localparam logic                        ActDecrypt = 1'b1;
  localparam logic [rme_pkg::CfgIdxW-1:0] CfgUnused  = 2'd3;

  typedef logic [rme_pkg::FieldW-1:0] word_t;

  typedef struct packed {
    word_t modulus;
    word_t pub_exp;
    word_t priv_exp;
    logic  act;
    word_t msg;
    logic  typed;
    word_t result;
  } vector_t;

  // modulus, public exp, private exp, action, message, typed, result
  localparam vector_t DirectedVectors [NumVectors] = '{
    '{32'd1, 32'd0, 32'd0, ActEncrypt, 32'h1234_5678, 1'b1, 32'd1},
    '{32'd1, 32'd0, 32'd0, ActDecrypt, 32'hFFFF_FFFF, 1'b1, 32'd1},
    '{32'd0, 32'd5, 32'd0, ActEncrypt, 32'd7, 1'b1, 32'd0},
    '{32'd0, 32'd5, 32'd0, ActDecrypt, 32'd7, 1'b1, 32'd1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, ActEncrypt, 32'd0, 1'b1, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, ActEncrypt, 32'd1, 1'b1, 32'd1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, ActEncrypt, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, ActDecrypt, 32'hFFFF_FFFF, 1'b1, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, ActDecrypt, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, ActEncrypt, 32'hDEAD_BEEF, 1'b0, 32'd0},
    '{32'd3233, 32'd17, 32'd2753, ActEncrypt, 32'd65, 1'b1, 32'd2790},
    '{32'd3233, 32'd17, 32'd2753, ActDecrypt, 32'd2790, 1'b1, 32'd65},
    '{32'd3233, 32'd17, 32'd2753, ActEncrypt, 32'd3298, 1'b1, 32'd2790},
    '{32'd3233, 32'd17, 32'd2753, ActDecrypt, 32'd0, 1'b1, 32'd0},
    '{32'd3233, 32'd17, 32'd2753, ActDecrypt, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{32'd2, 32'h8000_0000, 32'hFFFF_FFFF, ActEncrypt, 32'd3, 1'b1, 32'd1},
    '{32'd2, 32'h8000_0000, 32'hFFFF_FFFF, ActDecrypt, 32'd2, 1'b1, 32'd0},
    '{32'h8000_0000, 32'd2, 32'd3, ActEncrypt, 32'hFFFF_FFFF, 1'b1, 32'd1},
    '{32'h8000_0000, 32'd2, 32'd3, ActDecrypt, 32'h0001_0000, 1'b1, 32'd0},
    '{32'h8000_0000, 32'd2, 32'd3, ActDecrypt, 32'd3, 1'b1, 32'd27},
    '{32'h8000_0000, 32'd2, 32'd3, ActEncrypt, 32'h7FFF_FFFF, 1'b0, 32'd0}
  };

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic                        action_i    = ActEncrypt;
  word_t                       message_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  word_t                       result_o;
  logic                        cfg_we_i    = 1'b0;
  logic [rme_pkg::CfgIdxW-1:0] cfg_index_i = rme_pkg::CfgModulus;
  word_t                       cfg_data_i  = '0;

  // key registers as the block should hold them
  word_t key_modulus  = 32'd1;
  word_t key_pub_exp  = '0;
  word_t key_priv_exp = '0;

  word_t  expected_results [$];
  int     error_count = 0;
  longint cycle_count = 0;
  logic   quiet_mode  = 1'b0;
  logic   hold_req    = 1'b0;
  logic   hold_taken  = 1'b0;
  int     hold_left   = 0;

  rsa_modular_exponentiation #(
    .WIDTH(Width)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .message_i  (message_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // msg^ex mod m, exponent scanned from the LSB; a zero exponent leaves 1 unreduced
  function automatic word_t mod_power(word_t msg, word_t ex, word_t m);
    logic [63:0] base;
    logic [63:0] acc;
    base = msg % m;
    acc  = 64'd1;
    for (int i = 0; i < Width; i++) begin
      if ((ex >> i) == 0) break;
      if (ex[i]) acc = (base * (acc % m)) % m;
      base = (base * base) % m;
    end
    return acc[rme_pkg::FieldW-1:0];
  endfunction

  function automatic word_t pick_modulus();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return word_t'($urandom_range(255, 2));
      3: return {1'b1, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t pick_exponent();
    case ($urandom_range(6))
      0: return '0;
      1: return '1;
      2: return word_t'($urandom_range(15, 1));
      3: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t pick_message();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return key_modulus - 1'b1;
      3: return key_modulus + word_t'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  task automatic write_register(logic [rme_pkg::CfgIdxW-1:0] idx, word_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      rme_pkg::CfgModulus:    key_modulus  = (data == '0) ? 32'd1 : data;
      rme_pkg::CfgPublicExp:  key_pub_exp  = data;
      rme_pkg::CfgPrivateExp: key_priv_exp = data;
      default: ;
    endcase
  endtask

  task automatic configure(word_t m, word_t pe, word_t de, logic junk);
    write_register(rme_pkg::CfgModulus, m);
    write_register(rme_pkg::CfgPublicExp, pe);
    write_register(rme_pkg::CfgPrivateExp, de);
    if (junk) write_register(CfgUnused, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // valid stays high from one request to the next unless a gap is rolled or results are drained
  task automatic send_request(logic act, word_t msg, logic typed, word_t typed_result);
    word_t ex;
    while (!quiet_mode && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    message_i  <= msg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ex = (act == ActDecrypt) ? key_priv_exp : key_pub_exp;
    expected_results.push_back(typed ? typed_result : mod_power(msg, ex, key_modulus));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_mode && ($urandom_range(99) < 6);
    end
  end

  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result: expected none, actual %h", result_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_o !== want) begin
          $error("result: expected %h, actual %h", want, result_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("rsa_modular_exponentiation_tb: done, errors");
      $finish;
    end
  end

  initial begin
    word_t prev_mod;
    word_t prev_pub;
    word_t prev_priv;
    int    phase;
    int    sent;
    int    batch;
    word_t m;
    word_t pe;
    word_t de;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    prev_mod  = 32'd1;
    prev_pub  = '0;
    prev_priv = '0;
    foreach (DirectedVectors[v]) begin
      if (DirectedVectors[v].modulus != prev_mod || DirectedVectors[v].pub_exp != prev_pub ||
          DirectedVectors[v].priv_exp != prev_priv) begin
        drain_results();
        configure(DirectedVectors[v].modulus, DirectedVectors[v].pub_exp,
                  DirectedVectors[v].priv_exp, 1'b0);
        prev_mod  = DirectedVectors[v].modulus;
        prev_pub  = DirectedVectors[v].pub_exp;
        prev_priv = DirectedVectors[v].priv_exp;
      end
      send_request(DirectedVectors[v].act, DirectedVectors[v].msg,
                   DirectedVectors[v].typed, DirectedVectors[v].result);
    end

    // random phases; each begins only once every result of the last has come back
    phase = 0;
    sent  = 0;
    while (sent < RandomItems) begin
      drain_results();
      quiet_mode <= (phase == 1);
      if (phase == 3) begin
        m  = '1;
        pe = '1;
        de = '1;
      end else begin
        m  = pick_modulus();
        pe = pick_exponent();
        de = pick_exponent();
      end
      configure(m, pe, de, phase == 0 || $urandom_range(3) == 0);
      // receiver holds off long enough that the block backs up into the sender
      if (phase == 2) hold_req <= 1'b1;
      batch = $urandom_range(45, 15);
      repeat (batch) begin
        send_request(logic'($urandom_range(1)), pick_message(), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("rsa_modular_exponentiation_tb: done, clean");
    end else begin
      $display("rsa_modular_exponentiation_tb: done, errors");
    end
    $finish;
  end

endmodule
